// ===== hdl/fvd_pkg.sv =====
// ----------------------------------------------------------------------------
// fvd_pkg
// Types, operation codes and default sizes shared by the dedup fifo files.
// ----------------------------------------------------------------------------
package fvd_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   // operation codes; code three is a no-op
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_DEDUP   = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [3:0]         removed_count;
      logic [4:0]         occupancy;
      logic               is_empty;
      logic signed [31:0] head_value;
      logic               overflow;
   } rsp_type;

   // strobes from the dedup walker to the top level
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic done;
   } walk_ctl_type;

endpackage

// ===== hdl/fvd_ram.sv =====
// ----------------------------------------------------------------------------
// fvd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fvd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fvd_walk.sv =====
// ----------------------------------------------------------------------------
// fvd_walk
// Dedup walker: reads the queue from the head one entry a cycle and writes
// back every kept entry at the next compacted offset.
// ----------------------------------------------------------------------------
module fvd_walk #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [$clog2(DEPTH+1)-1:0]       total,
   input  logic [WORD_BITS-1:0]             match,
   input  logic [WORD_BITS-1:0]             rd_data,
   output logic [$clog2(DEPTH)-1:0]         rd_off,
   output logic [$clog2(DEPTH)-1:0]         wr_off,
   output logic [WORD_BITS-1:0]             wr_data,
   output logic [$clog2(DEPTH+1)-1:0]       kept,
   output logic [$clog2(DEPTH+1)-1:0]       removed,
   output fvd_pkg::walk_ctl_type            ctl
);
   import fvd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic                 active_ff, active_in;
   logic                 pend_ff, pend_in;
   logic                 seen_ff, seen_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0]        proc_cnt_ff, proc_cnt_in;
   logic [CW-1:0]        kept_ff, kept_in;
   logic [CW-1:0]        removed_ff, removed_in;
   logic [CW-1:0]        total_ff;
   logic [WORD_BITS-1:0] match_ff;
   logic                 rd_en;
   logic                 hit;
   logic                 keep;
   logic                 last;

   assign rd_en = active_ff && (rd_cnt_ff < total_ff);
   assign hit   = (rd_data == match_ff);
   assign keep  = !(hit && seen_ff);
   assign last  = pend_ff && (proc_cnt_ff == total_ff - CW'(1));

   always_comb begin
      active_in   = active_ff;
      rd_cnt_in   = rd_cnt_ff;
      proc_cnt_in = proc_cnt_ff;
      kept_in     = kept_ff;
      removed_in  = removed_ff;
      seen_in     = seen_ff;
      pend_in     = rd_en;
      done_in     = last;
      if (go) begin
         active_in   = 1'b1;
         rd_cnt_in   = '0;
         proc_cnt_in = '0;
         kept_in     = '0;
         removed_in  = '0;
         seen_in     = 1'b0;
      end else begin
         if (rd_en) begin
            rd_cnt_in = rd_cnt_ff + CW'(1);
         end
         if (pend_ff) begin
            proc_cnt_in = proc_cnt_ff + CW'(1);
            if (keep) begin
               kept_in = kept_ff + CW'(1);
            end else begin
               removed_in = removed_ff + CW'(1);
            end
            if (hit) begin
               seen_in = 1'b1;
            end
         end
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
         done_ff   <= done_in;
      end
      rd_cnt_ff   <= rd_cnt_in;
      proc_cnt_ff <= proc_cnt_in;
      kept_ff     <= kept_in;
      removed_ff  <= removed_in;
      seen_ff     <= seen_in;
      if (go) begin
         total_ff <= total;
         match_ff <= match;
      end
   end

   // writes trail reads, so a write never hits the entry being read
   assign rd_off    = rd_cnt_ff[AW-1:0];
   assign wr_off    = kept_ff[AW-1:0];
   assign wr_data   = rd_data;
   assign kept      = kept_ff;
   assign removed   = removed_ff;
   assign ctl.rd_en = rd_en;
   assign ctl.wr_en = pend_ff && keep;
   assign ctl.done  = done_ff;

endmodule

// ===== hdl/fifo_with_value_dedup_top.sv =====
// ----------------------------------------------------------------------------
// fifo_with_value_dedup_top
// Bounded fifo of words in a RAM with enqueue, dequeue and removal of later
// duplicates of a value.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single result
// appears on rsp_data with rsp_strobe high for one cycle, the cycle after the
// operation completes, and must be captured then since it cannot be held off.
// Enqueue, a dequeue that leaves the queue empty or finds it empty, the no-op
// code and a dedup on fewer than two words each complete without raising busy.
// A dequeue that leaves words behind raises busy in S_DEQ, waiting on the RAM
// read of the new head. During a dedup the walker reads one entry per cycle
// through the single read port and writes kept entries back behind it.
// A result may be on the port in the cycle a new operation is taken.
module fifo_with_value_dedup_top #(
   parameter int DEPTH     = fvd_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = fvd_pkg::WORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fvd_pkg::req_type req_data,
   output logic             rsp_strobe,
   output fvd_pkg::rsp_type rsp_data
);
   import fvd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_WALK
   } state_type;

   state_type            state_ff;
   logic [AW-1:0]        head_ff;
   logic [AW-1:0]        tail_ff;
   logic [CW-1:0]        count_ff;
   logic [WORD_BITS-1:0] head_word_ff;
   logic [WORD_BITS-1:0] popped_ff;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_ff;

   logic                 accept;
   logic [WORD_BITS-1:0] in_word;
   logic [AW-1:0]        head_next;
   logic [AW-1:0]        tail_next;
   logic [CW-1:0]        count_dec;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic                 walk_go;
   logic [AW-1:0]        walk_rd_off;
   logic [AW-1:0]        walk_wr_off;
   logic [WORD_BITS-1:0] walk_wr_data;
   logic [CW-1:0]        walk_kept;
   logic [CW-1:0]        walk_removed;
   walk_ctl_type         walk_ctl;

   function automatic logic [AW-1:0] add_wrap(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] fit_word(logic [31:0] x);
      logic [63:0] t;
      t = 64'(x);
      return t[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [31:0] to_field(logic [WORD_BITS-1:0] w);
      logic [63:0] t;
      t = 64'(w);
      return $signed(t[31:0]);
   endfunction

   assign accept    = start && (state_ff == S_IDLE);
   assign in_word   = fit_word(req_data.value);
   assign head_next = add_wrap(head_ff, CW'(1));
   assign tail_next = add_wrap(tail_ff, CW'(1));
   assign count_dec = count_ff - CW'(1);
   assign walk_go   = accept && (req_data.operation == OP_DEDUP) && (count_ff > CW'(1));

   // ram port steering: the walker owns both ports while it runs
   always_comb begin
      if (state_ff == S_WALK) begin
         ram_wr_en   = walk_ctl.wr_en;
         ram_wr_addr = add_wrap(head_ff, CW'(walk_wr_off));
         ram_wr_data = walk_wr_data;
         ram_rd_en   = walk_ctl.rd_en;
         ram_rd_addr = add_wrap(head_ff, CW'(walk_rd_off));
      end else begin
         ram_wr_en   = accept && (req_data.operation == OP_ENQUEUE) && (count_ff != FULL);
         ram_wr_addr = tail_ff;
         ram_wr_data = in_word;
         ram_rd_en   = accept && (req_data.operation == OP_DEQUEUE) && (count_ff > CW'(1));
         ram_rd_addr = head_next;
      end
   end

   fvd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fvd_walk #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .go      (walk_go),
      .total   (count_ff),
      .match   (in_word),
      .rd_data (ram_rd_data),
      .rd_off  (walk_rd_off),
      .wr_off  (walk_wr_off),
      .wr_data (walk_wr_data),
      .kept    (walk_kept),
      .removed (walk_removed),
      .ctl     (walk_ctl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff        <= 1'b0;
         rsp_ff.popped_value  <= '0;
         rsp_ff.removed_count <= '0;
         rsp_ff.overflow      <= 1'b0;
         rsp_ff.occupancy     <= 5'(count_ff);
         rsp_ff.is_empty      <= (count_ff == '0);
         rsp_ff.head_value    <= (count_ff == '0) ? '0 : to_field(head_word_ff);
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_strobe_ff <= 1'b1;
                  unique case (req_data.operation)
                     OP_ENQUEUE: begin
                        if (count_ff == FULL) begin
                           rsp_ff.overflow <= 1'b1;
                        end else begin
                           tail_ff          <= tail_next;
                           count_ff         <= count_ff + CW'(1);
                           rsp_ff.occupancy <= 5'(count_ff + CW'(1));
                           rsp_ff.is_empty  <= 1'b0;
                           if (count_ff == '0) begin
                              head_word_ff      <= in_word;
                              rsp_ff.head_value <= to_field(in_word);
                           end
                        end
                     end
                     OP_DEQUEUE: begin
                        if (count_ff != '0) begin
                           popped_ff           <= head_word_ff;
                           rsp_ff.popped_value <= to_field(head_word_ff);
                           head_ff             <= head_next;
                           count_ff            <= count_dec;
                           rsp_ff.occupancy    <= 5'(count_dec);
                           if (count_dec == '0) begin
                              tail_ff           <= head_next;
                              rsp_ff.is_empty   <= 1'b1;
                              rsp_ff.head_value <= '0;
                           end else begin
                              // result waits for the new head word
                              rsp_strobe_ff <= 1'b0;
                              state_ff      <= S_DEQ;
                           end
                        end
                     end
                     OP_DEDUP: begin
                        if (walk_go) begin
                           rsp_strobe_ff <= 1'b0;
                           state_ff      <= S_WALK;
                        end
                     end
                     OP_NOP: begin
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_DEQ: begin
               head_word_ff        <= ram_rd_data;
               rsp_strobe_ff       <= 1'b1;
               rsp_ff.popped_value <= to_field(popped_ff);
               rsp_ff.head_value   <= to_field(ram_rd_data);
               state_ff            <= S_IDLE;
            end
            S_WALK: begin
               // the head entry is always kept, so the head word stands
               if (walk_ctl.done) begin
                  count_ff             <= walk_kept;
                  tail_ff              <= add_wrap(head_ff, walk_kept);
                  rsp_strobe_ff        <= 1'b1;
                  rsp_ff.removed_count <= 4'(walk_removed);
                  rsp_ff.occupancy     <= 5'(walk_kept);
                  rsp_ff.is_empty      <= (walk_kept == '0);
                  state_ff             <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("occupancy above depth");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("ram read and write to the same entry");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("transfer accepted but neither result nor busy");

   a_walk_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_ctl.done |-> (state_ff == S_WALK))
      else $error("walker done outside dedup");

endmodule
